[sv/char_stream_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// char_stream_tokenizer_defines.svh
// Assertion macros shared by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define CST_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Types, constants and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int OUT_W         = 16;
    localparam int SYM_W         = 4;
    localparam int NUM_SYMS      = 9;
    localparam int QDEPTH        = 2;
    localparam int QAW           = 1;
    localparam int QCW           = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // + - * / ( ) ; , =
    localparam logic [7:0] SYM_CHARS [NUM_SYMS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h3B, 8'h2C, 8'h3D
    };

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_IDENT  = 2'd1,
        KIND_SYMBOL = 2'd2
    } t_kind;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] idx;
    } t_sym;

    // Work handed from front to back: an optional flushed word, then an
    // optional symbol, both on the same line.
    typedef struct packed {
        logic             has_word;
        t_kind            word_kind;
        logic [OUT_W-1:0] word_col;
        logic [OUT_W-1:0] word_len;
        logic             has_sym;
        logic [SYM_W-1:0] sym_idx;
        logic [OUT_W-1:0] sym_col;
        logic [OUT_W-1:0] line;
    } t_job;

    typedef struct packed {
        t_kind            kind;
        logic [SYM_W-1:0] symbol_index;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] column;
        logic [OUT_W-1:0] length;
        logic             last;
    } t_result;

    function automatic t_sym sym_lookup(input logic [7:0] ch);
        t_sym s;
        s = '0;
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (ch == SYM_CHARS[i]) begin
                s.hit = 1'b1;
                s.idx = SYM_W'(i);
            end
        end
        return s;
    endfunction

endpackage

[sv/cst_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_front
// Classifies each byte, tracks line, column and the pending word, and
// builds the job for the back end.
// ----------------------------------------------------------------------------
module cst_front #(
    parameter int POS_WIDTH = cst_pkg::POS_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_ch,
    input  logic          i_end_of_text,
    output logic          o_push,
    output cst_pkg::t_job o_job
);
    import cst_pkg::*;

    localparam logic [POS_WIDTH-1:0] PMAX = {POS_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0] ONE  = POS_WIDTH'(1);

    logic                 r_active, n_active;
    logic [POS_WIDTH-1:0] r_wcol, n_wcol;
    logic [POS_WIDTH-1:0] r_wlen, n_wlen;
    logic                 r_valid_chars, n_valid_chars;
    logic                 r_dot_seen, n_dot_seen;
    logic                 r_last_dot, n_last_dot;
    logic [POS_WIDTH-1:0] r_line, n_line;
    logic [POS_WIDTH-1:0] r_col, n_col;

    t_sym sym;
    logic is_ws, is_dot, is_digit;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == PMAX) ? v : v + ONE;
    endfunction

    always_comb begin
        sym      = sym_lookup(i_ch);
        is_ws    = i_ch inside {CH_SPACE, CH_NL, CH_TAB};
        is_dot   = (i_ch == CH_DOT);
        is_digit = i_ch inside {[CH_ZERO:CH_NINE]};

        o_job.has_word  = r_active;
        o_job.word_kind = (r_valid_chars && !r_last_dot) ? KIND_NUMBER : KIND_IDENT;
        o_job.word_col  = OUT_W'(r_wcol);
        o_job.word_len  = OUT_W'(r_wlen);
        o_job.has_sym   = 1'b0;
        o_job.sym_idx   = sym.idx;
        o_job.sym_col   = OUT_W'(r_col);
        o_job.line      = OUT_W'(r_line);

        n_active      = r_active;
        n_wcol        = r_wcol;
        n_wlen        = r_wlen;
        n_valid_chars = r_valid_chars;
        n_dot_seen    = r_dot_seen;
        n_last_dot    = r_last_dot;
        n_line        = r_line;
        n_col         = sat_inc(r_col);

        if (i_end_of_text) begin
            // flush, then back to the start of a fresh source
            n_active      = 1'b0;
            n_wcol        = ONE;
            n_wlen        = '0;
            n_valid_chars = 1'b1;
            n_dot_seen    = 1'b0;
            n_last_dot    = 1'b0;
            n_line        = ONE;
            n_col         = ONE;
        end else if (is_ws || sym.hit) begin
            o_job.has_sym = sym.hit;
            n_active      = 1'b0;
            n_wlen        = '0;
            n_valid_chars = 1'b1;
            n_dot_seen    = 1'b0;
            n_last_dot    = 1'b0;
            if (i_ch == CH_NL) begin
                n_line = sat_inc(r_line);
                n_col  = ONE;
            end
        end else begin
            o_job.has_word = 1'b0;
            if (!r_active) begin
                n_active      = 1'b1;
                n_wcol        = r_col;
                n_wlen        = ONE;
                n_valid_chars = is_digit;
                n_dot_seen    = is_dot;
            end else begin
                n_wlen = sat_inc(r_wlen);
                if (is_dot) begin
                    if (r_dot_seen) begin
                        n_valid_chars = 1'b0;
                    end
                    n_dot_seen = 1'b1;
                end else if (!is_digit) begin
                    n_valid_chars = 1'b0;
                end
            end
            n_last_dot = is_dot;
        end

        o_push = i_accept && (o_job.has_word || o_job.has_sym);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_wcol        <= ONE;
            r_wlen        <= '0;
            r_valid_chars <= 1'b1;
            r_dot_seen    <= 1'b0;
            r_last_dot    <= 1'b0;
            r_line        <= ONE;
            r_col         <= ONE;
        end else if (i_accept) begin
            r_active      <= n_active;
            r_wcol        <= n_wcol;
            r_wlen        <= n_wlen;
            r_valid_chars <= n_valid_chars;
            r_dot_seen    <= n_dot_seen;
            r_last_dot    <= n_last_dot;
            r_line        <= n_line;
            r_col         <= n_col;
        end
    end

endmodule

[sv/cst_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module cst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cst_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cst_pkg::t_job o_job
);
    import cst_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[sv/cst_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_back
// Expands each job into one or two token beats and holds them in an
// output register until taken.
// ----------------------------------------------------------------------------
module cst_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  cst_pkg::t_job    i_job,
    output logic             o_job_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output cst_pkg::t_result o_res
);
    import cst_pkg::*;

    logic    r_valid;
    logic    r_word_done, n_word_done;
    t_result r_res, n_res;
    logic    load;

    assign load    = i_job_valid && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_word_done = r_word_done;
        o_job_pop   = 1'b0;
        n_res.line  = i_job.line;
        if (i_job.has_word && !r_word_done) begin
            // word first; hold the job if a symbol follows
            n_res.kind         = i_job.word_kind;
            n_res.symbol_index = '0;
            n_res.column       = i_job.word_col;
            n_res.length       = i_job.word_len;
            n_res.last         = !i_job.has_sym;
            if (load) begin
                n_word_done = i_job.has_sym;
                o_job_pop   = !i_job.has_sym;
            end
        end else begin
            n_res.kind         = KIND_SYMBOL;
            n_res.symbol_index = i_job.sym_idx;
            n_res.column       = i_job.sym_col;
            n_res.length       = OUT_W'(1);
            n_res.last         = 1'b1;
            if (load) begin
                n_word_done = 1'b0;
                o_job_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_word_done <= 1'b0;
        end else begin
            r_word_done <= n_word_done;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

endmodule

[sv/char_stream_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Byte-stream lexical tokenizer emitting token descriptors.
// ----------------------------------------------------------------------------
// Push one source byte per beat (or an end-of-text beat) and pop token
// descriptors: kind, symbol index, line, start column and length. The block
// takes one byte per clock while the job queue has room; a byte that ends
// a word and is itself a symbol yields two result beats, and the two-entry
// job queue absorbs that burst. A descriptor's job is written into the queue
// when the byte that completes it is accepted, and the descriptor then moves
// into the output register once that register is free; the symbol behind a
// flushed word follows the word. An end-of-text beat flushes a pending word
// and returns line and column to 1 for a new source. Line, column and length
// saturate at 2^POS_WIDTH - 1; the ports carry their low 16 bits.
module char_stream_tokenizer #(
    parameter int POS_WIDTH = cst_pkg::POS_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input side
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_ch,
    input  logic                               i_end_of_text,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_kind,
    output logic [cst_pkg::SYM_W-1:0]          o_symbol_index,
    output logic [cst_pkg::OUT_W-1:0]          o_line,
    output logic [cst_pkg::OUT_W-1:0]          o_column,
    output logic [cst_pkg::OUT_W-1:0]          o_length,
    output logic                               o_last
);
    import cst_pkg::*;

    logic    accept;
    logic    job_push;
    t_job    front_job;
    logic    q_valid;
    t_job    q_job;
    logic    q_pop;
    t_result res;

    // a beat is taken whenever the queue has room; bytes that make no token
    // still advance the front state
    assign accept = push && !full;

    cst_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .o_push        (job_push),
        .o_job         (front_job)
    );

    // decouple classification from descriptor emission
    cst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    // drive result ports straight from the output register
    assign o_kind         = res.kind;
    assign o_symbol_index = res.symbol_index;
    assign o_line         = res.line;
    assign o_column       = res.column;
    assign o_length       = res.length;
    assign o_last         = res.last;

endmodule

[sv/cst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_stream_tokenizer_defines.svh"

module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [3:0]  o_symbol_index,
    input logic [15:0] o_line,
    input logic [15:0] o_column,
    input logic [15:0] o_length,
    input logic        o_last
);
    import cst_pkg::*;

    `CST_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, empty, "results present after reset")

    `CST_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_kind) && $stable(o_symbol_index) && $stable(o_line) && $stable(o_column) && $stable(o_length) && $stable(o_last), "waiting result changed")

    `CST_ASSERT_IMP(a_sym_beat, i_clk, i_rst_n, !empty && o_kind == KIND_SYMBOL, o_length == 16'd1 && o_last && o_symbol_index < 4'd9, "bad symbol beat")

    `CST_ASSERT_IMP(a_word_beat, i_clk, i_rst_n, !empty && o_kind != KIND_SYMBOL, o_symbol_index == 4'd0 && o_length != 16'd0 && o_line != 16'd0, "bad word beat")

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_symbol_index (o_symbol_index),
    .o_line         (o_line),
    .o_column       (o_column),
    .o_length       (o_length),
    .o_last         (o_last)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the byte-stream tokenizer.
// ----------------------------------------------------------------------------
// Push source bytes through the input queue and pop token descriptors from
// the result queue, with random gaps on both sides. Predict every descriptor
// in a behavioral copy of the scanner, then check each popped beat field by
// field against the oldest prediction. The run has three phases:
//  - a short scripted source with hand-written descriptors where they are
//    obvious (first symbol, simple words, end-of-text flush);
//  - a long random source made mostly of well-formed tokens, with a middle
//    stretch where neither side stalls;
//  - a drain that waits out every pending descriptor.
// ----------------------------------------------------------------------------
module tb;
    import cst_pkg::*;

    localparam int          MAX_CYCLES   = 100_000;
    localparam int          RAND_ITEMS   = 1580;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam t_result NO_TOK = '{KIND_NUMBER, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0};

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       typed;   // descriptor below is the expected one
        t_result    tok;
    } t_script_row;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [7:0]           i_ch          = 8'h00;
    logic                 i_end_of_text = 1'b0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic [1:0]           o_kind;
    logic [SYM_W-1:0]     o_symbol_index;
    logic [OUT_W-1:0]     o_line;
    logic [OUT_W-1:0]     o_column;
    logic [OUT_W-1:0]     o_length;
    logic                 o_last;

    // Hand-written expectation that travels with the current input beat.
    logic                 row_typed     = 1'b0;
    t_result              row_tok       = NO_TOK;

    // Suppress all idling on both sides while set.
    bit                   steady        = 1'b0;

    int unsigned          mismatches    = 0;
    int unsigned          beats_in      = 0;
    int unsigned          tokens_out    = 0;
    int unsigned          cycles        = 0;

    // Descriptors predicted but not yet popped, oldest first.
    t_result              pending_tokens [$];

    // Scanner state of the predictor.
    logic                 in_word;
    logic                 word_numeric;
    logic                 word_has_dot;
    logic                 word_ends_dot;
    logic [15:0]          word_col;
    logic [15:0]          word_len;
    logic [15:0]          cur_line;
    logic [15:0]          cur_col;

    // Descriptors caused by the beat just predicted.
    t_result              next_toks [2];
    int                   next_n;

    t_script_row          script [27];

    char_stream_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_symbol_index (o_symbol_index),
        .o_line         (o_line),
        .o_column       (o_column),
        .o_length       (o_length),
        .o_last         (o_last)
    );

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    // Position of the byte in the symbol set, -1 if it is not a symbol.
    function automatic int symbol_slot(input logic [7:0] c);
        int slot = -1;
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (SYM_CHARS[i] == c) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // Append one expected descriptor behind the ones already waiting.
    task automatic enqueue_token(input t_result t);
        pending_tokens = {pending_tokens, t};
    endtask

    // Return every counter to the start of a fresh source.
    task automatic restart_source();
        in_word       = 1'b0;
        word_numeric  = 1'b1;
        word_has_dot  = 1'b0;
        word_ends_dot = 1'b0;
        word_col      = 16'd1;
        word_len      = 16'd0;
        cur_line      = 16'd1;
        cur_col       = 16'd1;
    endtask

    // Emit the pending word, if any, with last low.
    task automatic close_word();
        t_result t;
        if (in_word) begin
            t.kind         = (word_numeric && !word_ends_dot) ? KIND_NUMBER : KIND_IDENT;
            t.symbol_index = '0;
            t.line         = cur_line;
            t.column       = word_col;
            t.length       = word_len;
            t.last         = 1'b0;
            next_toks[next_n] = t;
            next_n++;
            in_word       = 1'b0;
            word_len      = 16'd0;
            word_numeric  = 1'b1;
            word_has_dot  = 1'b0;
            word_ends_dot = 1'b0;
        end
    endtask

    // Advance the scanner by one accepted beat; results land in next_toks.
    task automatic scan_beat(input logic [7:0] c, input logic eot);
        int      slot;
        logic    is_dot;
        logic    is_digit;
        t_result t;
        slot     = symbol_slot(c);
        is_dot   = (c == CH_DOT);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        next_n   = 0;
        if (eot) begin
            // flush, then start a new source; the byte is ignored
            close_word();
            if (next_n > 0) begin
                next_toks[next_n-1].last = 1'b1;
            end
            restart_source();
        end else if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
            close_word();
            if (next_n > 0) begin
                next_toks[0].last = 1'b1;
            end
            if (c == CH_NL) begin
                cur_line = sat_up(cur_line);
                cur_col  = 16'd0;
            end
            cur_col = sat_up(cur_col);
        end else if (slot >= 0) begin
            close_word();
            t.kind         = KIND_SYMBOL;
            t.symbol_index = SYM_W'(slot);
            t.line         = cur_line;
            t.column       = cur_col;
            t.length       = 16'd1;
            t.last         = 1'b1;
            next_toks[next_n] = t;
            next_n++;
            cur_col = sat_up(cur_col);
        end else begin
            if (!in_word) begin
                in_word      = 1'b1;
                word_col     = cur_col;
                word_len     = 16'd1;
                word_numeric = is_digit;
                word_has_dot = is_dot;
            end else begin
                word_len = sat_up(word_len);
                if (is_dot) begin
                    if (word_has_dot) begin
                        word_numeric = 1'b0;
                    end
                    word_has_dot = 1'b1;
                end else if (!is_digit) begin
                    word_numeric = 1'b0;
                end
            end
            word_ends_dot = is_dot;
            cur_col = sat_up(cur_col);
        end
    endtask

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("[%0t] token %0d: %s expected %0d, got %0d",
                 $time, tokens_out, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Predict first, so an
    // expectation is always queued before its descriptor can be checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n && push && !full) begin
            scan_beat(i_ch, i_end_of_text);
            if (row_typed) begin
                enqueue_token(row_tok);
            end else begin
                for (int k = 0; k < next_n; k++) begin
                    enqueue_token(next_toks[k]);
                end
            end
            beats_in++;
        end
        if (i_rst_n && pop && !empty) begin
            got.kind         = t_kind'(o_kind);
            got.symbol_index = o_symbol_index;
            got.line         = o_line;
            got.column       = o_column;
            got.length       = o_length;
            got.last         = o_last;
            if (pending_tokens.size() == 0) begin
                report_mismatch("token with nothing pending, line", 0, got.line);
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", want.kind, got.kind);
                if (got.symbol_index !== want.symbol_index)
                    report_mismatch("symbol_index", want.symbol_index, got.symbol_index);
                if (got.line !== want.line)
                    report_mismatch("line", want.line, got.line);
                if (got.column !== want.column)
                    report_mismatch("column", want.column, got.column);
                if (got.length !== want.length)
                    report_mismatch("length", want.length, got.length);
                if (got.last !== want.last)
                    report_mismatch("last", want.last, got.last);
            end
            tokens_out++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: change inputs at the falling edge
    // ------------------------------------------------------------------------
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 30);
    endfunction

    // Result side: hold pop low during reset, then pop at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop = 1'b0;
        end else begin
            pop = !take_gap();
        end
    end

    // Offer one beat, after a random number of idle cycles, and hold it
    // until the block takes it. Leave push high so back-to-back beats flow.
    task automatic send_beat(input logic [7:0] c, input logic eot,
                             input logic typed, input t_result tok);
        @(negedge i_clk);
        while (take_gap()) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push          = 1'b1;
        i_ch          = c;
        i_end_of_text = eot;
        row_typed     = typed;
        row_tok       = tok;
        do @(posedge i_clk); while (full);
    endtask

    // Random source byte, weighted toward well-formed tokens.
    task automatic pick_beat(output logic [7:0] c, output logic eot);
        int unsigned r;
        r   = $urandom_range(99);
        eot = 1'b0;
        c   = 8'($urandom);
        if (r < 2) begin
            eot = 1'b1;                               // byte is noise
        end else if (r < 30) begin
            c = CH_ZERO + 8'($urandom_range(9));
        end else if (r < 38) begin
            c = CH_DOT;
        end else if (r < 55) begin
            c = "a" + 8'($urandom_range(25));
        end else if (r < 62) begin
            c = CH_SPACE;
        end else if (r < 66) begin
            c = CH_NL;
        end else if (r < 69) begin
            c = CH_TAB;
        end else if (r < 85) begin
            c = SYM_CHARS[$urandom_range(NUM_SYMS - 1)];
        end
        // else keep the fully random byte
    endtask

    // ------------------------------------------------------------------------
    // Scripted source. Columns advance by one per byte; a newline returns to
    // column 1 on the next line; end of text restarts at line 1, column 1.
    // ------------------------------------------------------------------------
    task automatic load_script();
        script = '{
            // symbol with no pending word
            '{"+",   1'b0, 1'b1, '{KIND_SYMBOL, 4'd0, 16'd1, 16'd1, 16'd1, 1'b1}},
            // number 9.5, then a symbol that ends it: two descriptors
            '{"9",   1'b0, 1'b0, NO_TOK},
            '{".",   1'b0, 1'b0, NO_TOK},
            '{"5",   1'b0, 1'b0, NO_TOK},
            '{"=",   1'b0, 1'b0, NO_TOK},
            // byte extremes form an identifier; space ends it
            '{8'h00, 1'b0, 1'b0, NO_TOK},
            '{8'hFF, 1'b0, 1'b0, NO_TOK},
            '{" ",   1'b0, 1'b1, '{KIND_IDENT, 4'd0, 16'd1, 16'd6, 16'd2, 1'b1}},
            // whitespace with no pending word
            '{"\t",  1'b0, 1'b0, NO_TOK},
            // leading dot makes an identifier; newline ends it
            '{".",   1'b0, 1'b0, NO_TOK},
            '{"5",   1'b0, 1'b0, NO_TOK},
            '{"\n",  1'b0, 1'b1, '{KIND_IDENT, 4'd0, 16'd1, 16'd10, 16'd2, 1'b1}},
            // trailing dot makes an identifier
            '{"0",   1'b0, 1'b0, NO_TOK},
            '{".",   1'b0, 1'b0, NO_TOK},
            '{";",   1'b0, 1'b0, NO_TOK},
            // two dots make an identifier; end of text flushes it
            '{"1",   1'b0, 1'b0, NO_TOK},
            '{".",   1'b0, 1'b0, NO_TOK},
            '{".",   1'b0, 1'b0, NO_TOK},
            '{"2",   1'b0, 1'b0, NO_TOK},
            '{8'h41, 1'b1, 1'b1, '{KIND_IDENT, 4'd0, 16'd2, 16'd4, 16'd4, 1'b1}},
            // new source starts at line 1, column 1
            '{"-",   1'b0, 1'b1, '{KIND_SYMBOL, 4'd1, 16'd1, 16'd1, 16'd1, 1'b1}},
            '{"*",   1'b0, 1'b0, NO_TOK},
            '{"/",   1'b0, 1'b0, NO_TOK},
            '{"(",   1'b0, 1'b0, NO_TOK},
            '{")",   1'b0, 1'b0, NO_TOK},
            '{",",   1'b0, 1'b0, NO_TOK},
            // end of text with nothing pending
            '{8'hFF, 1'b1, 1'b0, NO_TOK}
        };
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        logic [7:0] c;
        logic       eot;
        restart_source();
        load_script();

        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            send_beat(script[i].ch, script[i].eot, script[i].typed, script[i].tok);
        end

        // Random source; keep both sides busy through the middle stretch.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 600) && (n < 900);
            pick_beat(c, eot);
            send_beat(c, eot, 1'b0, NO_TOK);
        end
        steady = 1'b0;

        @(negedge i_clk);
        push = 1'b0;

        // Drain, then let a few more cycles pass to catch stray beats.
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d source beats pushed, %0d token descriptors popped",
                 beats_in, tokens_out);
        $display("covered all symbols, numbers, identifiers, end-of-text flushes "
                 , "and back-to-back beats under random stalls on both sides");
        if (mismatches == 0 && pending_tokens.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/cst_pkg.sv
sv/cst_front.sv
sv/cst_queue.sv
sv/cst_back.sv
sv/char_stream_tokenizer.sv
sv/cst_checker.sv
dv/tb.sv
